FILE: hw/rtl/assert_macros.svh
// assertion helpers included by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock while out of reset
`define DTS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// trigger in one cycle implies a property in the next cycle
`define DTS_ASSERT_NEXT(name, clk, rstn, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/dts_pkg.sv
`timescale 1ns / 1ps

package dts_pkg;

    // field widths fixed by the interface
    localparam int CMD_W  = 2;
    localparam int NODE_W = 4;
    localparam int CFG_W  = 5;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [NODE_W-1:0] node_t;
    typedef logic [CFG_W-1:0]  cfg_t;

    // command codes
    localparam cmd_t CMD_ADD   = 2'd0;
    localparam cmd_t CMD_SORT  = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

    // node count after reset
    localparam cfg_t NODE_COUNT_RESET = 5'd16;

    // input word
    typedef struct packed {
        cmd_t  command;
        node_t edge_from;
        node_t edge_to;
    } in_word_t;

    // result word
    typedef struct packed {
        node_t ordered_node;
        logic  last;
        logic  edges_dropped;
    } out_word_t;

endpackage

FILE: hw/rtl/dts_ram.sv
`timescale 1ns / 1ps

module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/dts_match.sv
`timescale 1ns / 1ps

module dts_match #(
    parameter int MAX_NODES = 16
) (
    input  dts_pkg::node_t                        edge_src,
    input  dts_pkg::node_t                        edge_dst,
    input  logic [$clog2(MAX_NODES)-1:0]          cur_node,
    input  logic [$clog2(MAX_NODES+1)-1:0]        node_limit,
    input  logic [MAX_NODES-1:0]                  visited,
    output logic                                  hit,
    output logic [$clog2(MAX_NODES)-1:0]          dst_idx
);

    localparam int NIW  = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int NVW  = (NIW > dts_pkg::NODE_W) ? NIW : dts_pkg::NODE_W;
    localparam int CMPW = CW + dts_pkg::NODE_W;

    logic src_match;
    logic dst_in_range;

    // edge leaves the current node and reaches a fresh node in range
    assign src_match    = NVW'(edge_src) == NVW'(cur_node);
    assign dst_in_range = CMPW'(edge_dst) < CMPW'(node_limit);
    assign dst_idx      = NIW'(edge_dst);
    assign hit          = src_match && dst_in_range && !visited[dst_idx];

endmodule

FILE: hw/rtl/dts_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dts_core #(
    parameter int MAX_NODES = 16,
    parameter int MAX_EDGES = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dts_pkg::in_word_t              s_data,
    input  logic [$clog2(MAX_NODES+1)-1:0] node_limit,
    output logic                           emit_valid,
    input  logic                           emit_ready,
    output dts_pkg::out_word_t             emit_word
);

    localparam int NIW  = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int EW   = $clog2(MAX_EDGES + 1);
    localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CMPW = CW + dts_pkg::NODE_W;
    localparam int EDW  = 2 * dts_pkg::NODE_W;
    localparam int SW   = NIW + EW;

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_START     = 3'd1;
    localparam logic [2:0] ST_SCAN_RD   = 3'd2;
    localparam logic [2:0] ST_SCAN_CHK  = 3'd3;
    localparam logic [2:0] ST_POP_LOAD  = 3'd4;
    localparam logic [2:0] ST_EMIT_RD   = 3'd5;
    localparam logic [2:0] ST_EMIT_WAIT = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [EW-1:0]        edge_total_reg, edge_total_next;
    logic                 drop_reg, drop_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [CW-1:0]        start_reg, start_next;
    logic [CW-1:0]        depth_reg, depth_next;
    logic [NIW-1:0]       cur_u_reg, cur_u_next;
    logic [EW-1:0]        cur_p_reg, cur_p_next;
    logic [CW-1:0]        finish_total_reg, finish_total_next;
    logic [NIW-1:0]       emit_idx_reg, emit_idx_next;

    logic                 edge_we, edge_re;
    logic [AW-1:0]        edge_waddr, edge_raddr;
    logic [EDW-1:0]       edge_wdata, edge_rdata;
    logic                 stack_we, stack_re;
    logic [NIW-1:0]       stack_waddr, stack_raddr;
    logic [SW-1:0]        stack_wdata, stack_rdata;
    logic                 fin_we, fin_re;
    logic [NIW-1:0]       fin_waddr, fin_raddr;
    logic [NIW-1:0]       fin_rdata;

    logic                 hit;
    logic [NIW-1:0]       dst_idx;
    logic [EW-1:0]        cur_p_dec;
    logic [CW-1:0]        depth_m1, depth_m2;
    logic [NIW-1:0]       start_idx;
    logic                 add_bad;

    // edge table: source in the upper half, target in the lower half
    dts_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES), .AW(AW)) u_edge_ram (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // saved stack frames below the current top: node and scan position
    dts_ram #(.WIDTH(SW), .DEPTH(MAX_NODES), .AW(NIW)) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // post-order of finished nodes
    dts_ram #(.WIDTH(NIW), .DEPTH(MAX_NODES), .AW(NIW)) u_finish_ram (
        .aclk  (aclk),
        .we    (fin_we),
        .waddr (fin_waddr),
        .wdata (cur_u_reg),
        .re    (fin_re),
        .raddr (fin_raddr),
        .rdata (fin_rdata)
    );

    // shared edge compare unit, one edge per check
    dts_match #(.MAX_NODES(MAX_NODES)) u_match (
        .edge_src   (edge_rdata[EDW-1:dts_pkg::NODE_W]),
        .edge_dst   (edge_rdata[dts_pkg::NODE_W-1:0]),
        .cur_node   (cur_u_reg),
        .node_limit (node_limit),
        .visited    (visited_reg),
        .hit        (hit),
        .dst_idx    (dst_idx)
    );

    assign cur_p_dec = cur_p_reg - 1'b1;
    assign depth_m1  = depth_reg - 1'b1;
    assign depth_m2  = depth_reg - CW'(2);
    assign start_idx = start_reg[NIW-1:0];
    assign add_bad   = (CMPW'(s_data.edge_from) >= CMPW'(node_limit))
                    || (CMPW'(s_data.edge_to) >= CMPW'(node_limit))
                    || (edge_total_reg == EW'(MAX_EDGES));

    assign s_ready    = state_reg == ST_IDLE;
    assign emit_valid = state_reg == ST_EMIT_WAIT;

    // result word from the finish order, newest first
    always_comb begin
        emit_word.ordered_node  = dts_pkg::node_t'(fin_rdata);
        emit_word.last          = emit_idx_reg == '0;
        emit_word.edges_dropped = drop_reg;
    end

    // sequencer
    always_comb begin
        state_next        = state_reg;
        edge_total_next   = edge_total_reg;
        drop_next         = drop_reg;
        visited_next      = visited_reg;
        start_next        = start_reg;
        depth_next        = depth_reg;
        cur_u_next        = cur_u_reg;
        cur_p_next        = cur_p_reg;
        finish_total_next = finish_total_reg;
        emit_idx_next     = emit_idx_reg;

        edge_we     = 1'b0;
        edge_waddr  = edge_total_reg[AW-1:0];
        edge_wdata  = {s_data.edge_from, s_data.edge_to};
        edge_re     = 1'b0;
        edge_raddr  = cur_p_dec[AW-1:0];
        stack_we    = 1'b0;
        stack_waddr = depth_m1[NIW-1:0];
        stack_wdata = {cur_u_reg, cur_p_reg};
        stack_re    = 1'b0;
        stack_raddr = depth_m2[NIW-1:0];
        fin_we      = 1'b0;
        fin_waddr   = finish_total_reg[NIW-1:0];
        fin_re      = 1'b0;
        fin_raddr   = emit_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.command)
                        dts_pkg::CMD_ADD: begin
                            if (add_bad) begin
                                drop_next = 1'b1;
                            end else begin
                                edge_we         = 1'b1;
                                edge_total_next = edge_total_reg + 1'b1;
                            end
                        end
                        dts_pkg::CMD_SORT: begin
                            visited_next      = '0;
                            finish_total_next = '0;
                            start_next        = '0;
                            state_next        = ST_START;
                        end
                        dts_pkg::CMD_CLEAR: begin
                            edge_total_next = '0;
                            drop_next       = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // walk start nodes in ascending order
            ST_START: begin
                if (start_reg == node_limit) begin
                    if (finish_total_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_idx_next = NIW'(finish_total_reg - 1'b1);
                        state_next    = ST_EMIT_RD;
                    end
                end else if (visited_reg[start_idx]) begin
                    start_next = start_reg + 1'b1;
                end else begin
                    cur_u_next              = start_idx;
                    cur_p_next              = edge_total_reg;
                    depth_next              = CW'(1);
                    visited_next[start_idx] = 1'b1;
                    state_next              = ST_SCAN_RD;
                end
            end
            // fetch the next older edge, or finish the top node
            ST_SCAN_RD: begin
                if (cur_p_reg == '0) begin
                    if (finish_total_reg != CW'(MAX_NODES)) begin
                        fin_we            = 1'b1;
                        finish_total_next = finish_total_reg + 1'b1;
                    end
                    depth_next = depth_m1;
                    if (depth_reg == CW'(1)) begin
                        state_next = ST_START;
                    end else begin
                        stack_re   = 1'b1;
                        state_next = ST_POP_LOAD;
                    end
                end else begin
                    edge_re    = 1'b1;
                    cur_p_next = cur_p_dec;
                    state_next = ST_SCAN_CHK;
                end
            end
            // descend into a fresh successor
            ST_SCAN_CHK: begin
                if (hit && depth_reg != CW'(MAX_NODES)) begin
                    stack_we              = 1'b1;
                    cur_u_next            = dst_idx;
                    cur_p_next            = edge_total_reg;
                    visited_next[dst_idx] = 1'b1;
                    depth_next            = depth_reg + 1'b1;
                end
                state_next = ST_SCAN_RD;
            end
            ST_POP_LOAD: begin
                cur_u_next = stack_rdata[SW-1:EW];
                cur_p_next = stack_rdata[EW-1:0];
                state_next = ST_SCAN_RD;
            end
            ST_EMIT_RD: begin
                fin_re     = 1'b1;
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (emit_ready) begin
                    if (emit_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg - 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            edge_total_reg   <= '0;
            drop_reg         <= 1'b0;
            visited_reg      <= '0;
            start_reg        <= '0;
            depth_reg        <= '0;
            finish_total_reg <= '0;
            emit_idx_reg     <= '0;
        end else begin
            state_reg        <= state_next;
            edge_total_reg   <= edge_total_next;
            drop_reg         <= drop_next;
            visited_reg      <= visited_next;
            start_reg        <= start_next;
            depth_reg        <= depth_next;
            finish_total_reg <= finish_total_next;
            emit_idx_reg     <= emit_idx_next;
        end
    end

    // search position registers
    always_ff @(posedge aclk) begin
        cur_u_reg <= cur_u_next;
        cur_p_reg <= cur_p_next;
    end

    // checks
    `DTS_ASSERT(a_depth_bound, aclk, aresetn, depth_reg <= CW'(MAX_NODES), "stack depth overflow")
    `DTS_ASSERT(a_edge_bound, aclk, aresetn, edge_total_reg <= EW'(MAX_EDGES), "edge count overflow")
    `DTS_ASSERT(a_top_visited, aclk, aresetn, (state_reg != ST_SCAN_RD) || visited_reg[cur_u_reg], "node on stack not marked visited")
    `DTS_ASSERT(a_emit_in_range, aclk, aresetn, !emit_valid || (CW'(emit_idx_reg) < finish_total_reg), "emit index beyond finish order")
    `DTS_ASSERT_NEXT(a_sort_clears, aclk, aresetn, s_valid && s_ready && (s_data.command == dts_pkg::CMD_SORT), (visited_reg == '0) && (finish_total_reg == '0), "sort did not clear marks")

endmodule

FILE: hw/rtl/dfs_topological_sort.sv
// operation: add and clear are handled in the idle state; a sort walks the start nodes, scans the
// stored edges of each visited node, newest first, then emits result words, newest finished first
// input: one word at a time, refused while a sort runs; each edge is read from the table, then checked
// results leave through an output register, so a finished word may wait while the next runs
// reset: synchronous active low; clears edges, drop flag, marks and counts, node_count = 16
`timescale 1ns / 1ps

module dfs_topological_sort #(
    parameter int MAX_NODES = 16,
    parameter int MAX_EDGES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dts_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dts_pkg::out_word_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  dts_pkg::cfg_t      cfg_data
);

    localparam int CW = $clog2(MAX_NODES + 1);

    dts_pkg::cfg_t      node_count_reg;
    logic [CW-1:0]      node_limit;
    logic               m_valid_reg;
    dts_pkg::out_word_t m_data_reg;
    logic               emit_valid;
    logic               emit_ready;
    dts_pkg::out_word_t emit_word;

    // node count register, clamped to the node capacity
    assign cfg_ready  = 1'b1;
    assign node_limit = (int'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES)
                                                           : CW'(node_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= dts_pkg::NODE_COUNT_RESET;
        end else if (cfg_valid) begin
            node_count_reg <= cfg_data;
        end
    end

    dts_core #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .node_limit (node_limit),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_word  (emit_word)
    );

    // output register
    assign emit_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_ready) begin
            m_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_ready && emit_valid) begin
            m_data_reg <= emit_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
